FILE: rtl/msd_pkg.sv
// msd_pkg: shared widths, reciprocal constants, position codes and the
// seven-segment digit table for the multiplexed display driver
// depends on nothing
`default_nettype none

package msd_pkg;

  localparam int VALUE_W  = 17;
  localparam int IP_W     = 11;   // integer part, up to 1310
  localparam int Q10_W    = 8;    // integer part / 10, up to 131
  localparam int Q100_W   = 4;    // integer part / 100, up to 13
  localparam int FRAC_W   = 7;    // hundredths remainder, 0..99
  localparam int DIG_W    = 4;
  localparam int SEG_W    = 7;
  localparam int POS_W    = 2;
  localparam int DIGITS   = 4;

  // reciprocal multipliers, exact over the full input range of each operand
  localparam int RECIP_W100  = 18;
  localparam logic [RECIP_W100-1:0] RECIP_V100 = 18'd167773;
  localparam int SHIFT_V100  = 24;
  localparam logic [IP_W-1:0] RECIP_IP10  = 11'd1639;
  localparam int SHIFT_IP10  = 14;
  localparam logic [IP_W-1:0] RECIP_IP100 = 11'd1311;
  localparam int SHIFT_IP100 = 17;
  localparam logic [FRAC_W-1:0] RECIP_F10 = 7'd103;
  localparam int SHIFT_F10   = 10;

  localparam logic [POS_W-1:0] POS_LEFT   = 2'd0;
  localparam logic [POS_W-1:0] POS_MID    = 2'd1;
  localparam logic [POS_W-1:0] POS_RIGHT  = 2'd2;
  localparam logic [POS_W-1:0] POS_DEGREE = 2'd3;

  localparam logic [SEG_W-1:0] DEGREE_PATTERN = 7'h69;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } sample_t;

  typedef struct packed {
    logic [IP_W-1:0]   int_part;
    logic [FRAC_W-1:0] frac;
    logic [POS_W-1:0]  pos;
  } coarse_t;

  typedef struct packed {
    logic [IP_W-1:0]   int_part;
    logic [Q10_W-1:0]  q10;
    logic [Q100_W-1:0] q100;
    logic [FRAC_W-1:0] frac;
    logic [DIG_W-1:0]  tenths;
    logic [POS_W-1:0]  pos;
  } split_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h77;
      4'd1:    s = 7'h24;
      4'd2:    s = 7'h7A;
      4'd3:    s = 7'h6E;
      4'd4:    s = 7'h2D;
      4'd5:    s = 7'h4F;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h64;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msd_digit_split.sv
// msd_digit_split: input register and two reciprocal-multiply stages that
// split the hundredths value into quotients by 100, 1000 and 10000
// depends on msd_pkg
`default_nettype none

module msd_digit_split
  import msd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [VALUE_W-1:0]   value,
  input  wire logic [POS_W-1:0]     pos,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output split_t                    out_split
);

  logic    smp_vld_r, crs_vld_r, spl_vld_r;
  sample_t smp_r;
  coarse_t crs_r, crs_nxt;
  split_t  spl_r, spl_nxt;
  logic    smp_rdy, crs_rdy, spl_rdy;

  logic [VALUE_W+RECIP_W100-1:0] p100;
  logic [VALUE_W-1:0]            ip_x100;
  logic [2*IP_W-1:0]             p10, pq100;
  logic [2*FRAC_W-1:0]           pf10;

  assign spl_rdy  = !spl_vld_r || out_ready;
  assign crs_rdy  = !crs_vld_r || spl_rdy;
  assign smp_rdy  = !smp_vld_r || crs_rdy;
  assign in_ready = smp_rdy;

  // value / 100 and the hundredths remainder
  always_comb begin
    p100             = {{RECIP_W100{1'b0}}, smp_r.value} *
                       {{VALUE_W{1'b0}}, RECIP_V100};
    crs_nxt.int_part = p100[SHIFT_V100 +: IP_W];
    ip_x100          = VALUE_W'(crs_nxt.int_part) * VALUE_W'(100);
    crs_nxt.frac     = FRAC_W'(smp_r.value - ip_x100);
    crs_nxt.pos      = smp_r.pos;
  end

  // integer part / 10, / 100 and remainder / 10
  always_comb begin
    p10              = {{IP_W{1'b0}}, crs_r.int_part} * {{IP_W{1'b0}}, RECIP_IP10};
    pq100            = {{IP_W{1'b0}}, crs_r.int_part} * {{IP_W{1'b0}}, RECIP_IP100};
    pf10             = {{FRAC_W{1'b0}}, crs_r.frac} * {{FRAC_W{1'b0}}, RECIP_F10};
    spl_nxt.int_part = crs_r.int_part;
    spl_nxt.q10      = p10[SHIFT_IP10 +: Q10_W];
    spl_nxt.q100     = pq100[SHIFT_IP100 +: Q100_W];
    spl_nxt.frac     = crs_r.frac;
    spl_nxt.tenths   = pf10[SHIFT_F10 +: DIG_W];
    spl_nxt.pos      = crs_r.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      crs_vld_r <= 1'b0;
      spl_vld_r <= 1'b0;
    end else begin
      if (smp_rdy) smp_vld_r <= in_valid;
      if (crs_rdy) crs_vld_r <= smp_vld_r;
      if (spl_rdy) spl_vld_r <= crs_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_rdy && in_valid) begin
      smp_r.value <= value;
      smp_r.pos   <= pos;
    end
    if (crs_rdy && smp_vld_r) crs_r <= crs_nxt;
    if (spl_rdy && crs_vld_r) spl_r <= spl_nxt;
  end

  assign out_valid = spl_vld_r;
  assign out_split = spl_r;

endmodule

`default_nettype wire

FILE: rtl/msd_window.sv
// msd_window: final digit correction, three-digit window select, segment
// decode and the registered result word
// depends on msd_pkg
`default_nettype none

module msd_window
  import msd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire split_t             in_split,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DIGITS-1:0]       out_enable,
  output logic [SEG_W-1:0]        out_segments,
  output logic                    out_point
);

  logic [DIG_W-1:0]  units, tens, hundreds, hund;
  logic [IP_W-1:0]   units_w;
  logic [Q10_W-1:0]  tens_w;
  logic [FRAC_W-1:0] hund_w;
  logic [DIG_W-1:0]  shown;
  logic              point_nxt;
  logic [SEG_W-1:0]  seg_nxt;
  logic [DIGITS-1:0] en_nxt;

  logic              vld_r;
  logic [DIGITS-1:0] en_r;
  logic [SEG_W-1:0]  seg_r;
  logic              point_r;

  assign in_ready = !vld_r || !out_stall;

  always_comb begin
    units_w  = in_split.int_part - IP_W'(in_split.q10) * IP_W'(10);
    tens_w   = in_split.q10 - Q10_W'(in_split.q100) * Q10_W'(10);
    hund_w   = in_split.frac - FRAC_W'(in_split.tenths) * FRAC_W'(10);
    units    = units_w[DIG_W-1:0];
    tens     = tens_w[DIG_W-1:0];
    hund     = hund_w[DIG_W-1:0];
    // above 999 the hundreds digit wraps
    hundreds = (in_split.q100 >= Q100_W'(10)) ? in_split.q100 - Q100_W'(10)
                                              : in_split.q100;
    shown     = '0;
    point_nxt = 1'b0;
    unique case (in_split.pos)
      POS_LEFT: begin
        priority if (hundreds != '0) shown = hundreds;
        else if (tens != '0) shown = tens;
        else begin
          shown     = units;
          point_nxt = 1'b1;
        end
      end
      POS_MID: begin
        priority if (hundreds != '0) shown = tens;
        else if (tens != '0) begin
          shown     = units;
          point_nxt = 1'b1;
        end else shown = in_split.tenths;
      end
      POS_RIGHT: begin
        priority if (hundreds != '0) shown = units;
        else if (tens != '0) shown = in_split.tenths;
        else shown = hund;
      end
      POS_DEGREE: shown = '0;
      default:    shown = '0;
    endcase
    seg_nxt = (in_split.pos == POS_DEGREE) ? DEGREE_PATTERN : seg_of(shown);
    en_nxt  = DIGITS'(1) << in_split.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      en_r    <= en_nxt;
      seg_r   <= seg_nxt;
      point_r <= point_nxt;
    end
  end

  assign out_valid    = vld_r;
  assign out_enable   = en_r;
  assign out_segments = seg_r;
  assign out_point    = point_r;

endmodule

`default_nettype wire

FILE: rtl/mux_seven_segment_decimal_display_top.sv
// mux_seven_segment_decimal_display_top: scan counter plus the digit split
// pipeline and window/decode stage of the four-position display driver
// depends on msd_pkg, msd_digit_split, msd_window
`default_nettype none

// Each accepted word is one refresh tick carrying a value in hundredths
// (0..99999). The scan position advances first, so the first tick after
// reset drives position 1. Positions 0..2 show HTU, TU.d or U.dh depending
// on the magnitude, with the point on the units digit; position 3 shows a
// degree sign. One word is accepted per cycle while in_stall is low; its
// result word reaches the outputs through an input register,
// a divide-by-100 reciprocal multiply stage, a divide-by-10/100 reciprocal
// multiply stage and the output register behind the window select and
// segment decode. Each stage holds its word on out_stall and empty stages
// still take words, so a stalled output does not stop the input until the
// pipeline is full.
module mux_seven_segment_decimal_display_top
  import msd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_W-1:0]     in_value_hundredths,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DIGITS-1:0]           out_digit_enable,
  output logic [SEG_W-1:0]            out_segment_bits,
  output logic                        out_point_on
);

  localparam int SCAN_W = $clog2(DIGITS);

  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              split_ready;
  logic              accept;
  logic              split_valid;
  logic              win_ready;
  split_t            split;
  logic [DIGITS-1:0] enable;

  assign in_stall = !split_ready;
  assign accept   = in_valid && split_ready;

  // advance before driving: the tick shows the next position
  assign scan_nxt = (scan_r == SCAN_W'(DIGITS - 1)) ? '0 : scan_r + SCAN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (accept) begin
      scan_r <= scan_nxt;
    end
  end

  msd_digit_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (split_ready),
    .value     (in_value_hundredths),
    .pos       (POS_W'(scan_nxt)),
    .out_valid (split_valid),
    .out_ready (win_ready),
    .out_split (split)
  );

  msd_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (split_valid),
    .in_ready     (win_ready),
    .in_split     (split),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_enable   (enable),
    .out_segments (out_segment_bits),
    .out_point    (out_point_on)
  );

  assign out_digit_enable = enable;

`ifndef SYNTHESIS
  // scan position only moves on an accepted tick
  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(scan_r))
    else $error("scan position moved without an accepted word");

  // exactly one digit driven per result word
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_digit_enable))
    else $error("digit enable not one-hot");

  // the point can only sit on position 0 or 1
  a_point_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_point_on) |-> (out_digit_enable[0] || out_digit_enable[1]))
    else $error("decimal point on wrong position");

  // degree position always carries the degree pattern
  a_degree: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_digit_enable[DIGITS-1]) |->
      (out_segment_bits == DEGREE_PATTERN && !out_point_on))
    else $error("degree position pattern wrong");
`endif

endmodule

`default_nettype wire
